/* rtl/dsfr_pkg.sv */
// Shared types and constants for the DLE stuffed frame receiver.
// No dependencies.
package dsfr_pkg;

    typedef enum logic [2:0]
    {
        PH_IDLE  = 3'd0,
        PH_CHECK = 3'd1,
        PH_TYPE  = 3'd2,
        PH_IDENT = 3'd3,
        PH_DATA  = 3'd4
    } rx_phase_t;

    typedef enum logic [1:0]
    {
        CMD_BYTE    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } command_t;

    typedef enum logic [1:0]
    {
        REG_START  = 2'd0,
        REG_END    = 2'd1,
        REG_ESCAPE = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    localparam logic [5:0] MK_START = 6'h01;
    localparam logic [5:0] MK_CHECK = 6'h02;
    localparam logic [5:0] MK_TYPE  = 6'h04;
    localparam logic [5:0] MK_IDENT = 6'h08;
    localparam logic [5:0] MK_DATA  = 6'h10;
    localparam logic [5:0] MK_END   = 6'h20;
    localparam logic [5:0] MK_NEED  = MK_START | MK_CHECK | MK_TYPE | MK_IDENT | MK_END;

    localparam logic [7:0] START_RESET  = 8'd2;
    localparam logic [7:0] END_RESET    = 8'd3;
    localparam logic [7:0] ESCAPE_RESET = 8'd16;

endpackage

/* rtl/dsfr_if.sv */
// Handshake channel interfaces: input items, result items, register writes.
// No dependencies.
interface dsfr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [5:0] read_index;

    modport source (output valid, command, rx_byte, read_index, input ready);
    modport sink (input valid, command, rx_byte, read_index, output ready);
endinterface

interface dsfr_result_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic       frame_held;
    logic       byte_ignored;
    logic [7:0] check_byte;
    logic [7:0] type_byte;
    logic [7:0] ident_byte;
    logic [6:0] payload_length;
    logic [7:0] read_data;
    logic       payload_overflow;

    modport source (output valid, frame_done, frame_held, byte_ignored, check_byte,
                    type_byte, ident_byte, payload_length, read_data,
                    payload_overflow, input ready);
    modport sink (input valid, frame_done, frame_held, byte_ignored, check_byte,
                  type_byte, ident_byte, payload_length, read_data,
                  payload_overflow, output ready);
endinterface

interface dsfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dle_stuffed_frame_receiver.sv */
// Top level of the DLE stuffed frame receiver.
// Depends on dsfr_pkg, dsfr_if and dsfr_payload_buf.
//
// Usage:
//   item   : one beat per command. command 0 feeds a link byte (rx_byte),
//            command 1 reads payload entry read_index, command 2 releases a
//            held frame, command 3 only reports status.
//   result : one beat per item, status after that item plus read_data.
//   cfg    : register writes (0 start, 1 end, 2 escape marker), always ready;
//            write only while no item is in flight.
// The result is registered: it is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the result is not stalled; the payload
//   memory takes one write or one read per item.
// A stalled result holds in the output register; item.ready stays high as
//   long as that register is empty or is being drained in the same cycle.
// Reset: markers return to 2/3/16, frame state and counts clear, no frame is
//   held. Payload memory is not cleared; entries read before written are
//   undefined.
module dle_stuffed_frame_receiver #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    dsfr_item_if.sink     item,
    dsfr_result_if.source result,
    dsfr_cfg_if.sink      cfg
);

    import dsfr_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

    logic [7:0]    start_reg;
    logic [7:0]    end_reg;
    logic [7:0]    escape_reg;

    rx_phase_t     phase_reg, phase_next;
    logic          esc_reg, esc_next;
    logic [5:0]    marks_reg, marks_next;
    logic          held_reg, held_next;
    logic [7:0]    check_reg, check_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    ident_reg, ident_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] length_reg, length_next;
    logic          ovf_reg, ovf_next;

    logic          out_valid_reg;
    logic          done_reg;
    logic          ignored_reg;

    logic          accept;
    logic          is_byte;
    logic          take;
    logic          literal;
    logic          hit_escape;
    logic          hit_start;
    logic          hit_end;
    logic          frame_ok;
    logic          room;
    logic          done_c;
    logic          ignored_c;
    logic          wr_en;
    logic [CW+6:0] length_ext;

    assign accept     = item.valid && item.ready;
    assign item.ready = !out_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign is_byte    = (item.command == CMD_BYTE);
    assign take       = accept && is_byte && !held_reg;
    assign literal    = esc_reg;
    assign hit_escape = !literal && (item.rx_byte == escape_reg);
    assign hit_start  = !literal && (item.rx_byte == start_reg);
    assign hit_end    = !literal && (item.rx_byte == end_reg);
    assign frame_ok   = ((marks_reg | MK_END) & MK_NEED) == MK_NEED;
    assign room       = (32'(count_reg) < 32'(PAYLOAD_DEPTH));
    assign ignored_c  = accept && is_byte && held_reg;
    assign done_c     = take && !hit_escape && !hit_start && hit_end && frame_ok;
    assign wr_en      = take && !hit_escape && !hit_start && !hit_end
                        && (phase_reg == PH_DATA) && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RESET;
            end_reg    <= END_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (reg_index_t'(cfg.index))
                REG_START:  start_reg  <= cfg.data;
                REG_END:    end_reg    <= cfg.data;
                REG_ESCAPE: escape_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (take && !hit_escape)
        begin
            if (hit_start)
            begin
                phase_next = PH_CHECK;
            end
            else if (hit_end)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_CHECK: phase_next = PH_TYPE;
                    PH_TYPE:  phase_next = PH_IDENT;
                    PH_IDENT: phase_next = PH_DATA;
                    PH_DATA:  phase_next = PH_DATA;
                    default:  phase_next = phase_reg;
                endcase
            end
        end
    end

    // frame contents and flags
    always_comb
    begin
        esc_next    = esc_reg;
        marks_next  = marks_reg;
        held_next   = held_reg;
        check_next  = check_reg;
        type_next   = type_reg;
        ident_next  = ident_reg;
        count_next  = count_reg;
        length_next = length_reg;
        ovf_next    = ovf_reg;
        if (accept && (item.command == CMD_RELEASE))
        begin
            held_next = 1'b0;
        end
        if (take)
        begin
            esc_next = hit_escape;
            if (hit_escape)
            begin
                esc_next = 1'b1;
            end
            else if (hit_start)
            begin
                marks_next = MK_START;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (hit_end)
            begin
                length_next = count_reg;
                marks_next  = frame_ok ? 6'd0 : (marks_reg | MK_END);
                held_next   = frame_ok;
            end
            else
            begin
                case (phase_reg)
                    PH_CHECK:
                    begin
                        check_next = item.rx_byte;
                        marks_next = marks_reg | MK_CHECK;
                    end
                    PH_TYPE:
                    begin
                        type_next  = item.rx_byte;
                        marks_next = marks_reg | MK_TYPE;
                    end
                    PH_IDENT:
                    begin
                        ident_next = item.rx_byte;
                        marks_next = marks_reg | MK_IDENT;
                    end
                    PH_DATA:
                    begin
                        if (room)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        marks_next = marks_reg | MK_DATA;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            esc_reg    <= 1'b0;
            marks_reg  <= 6'd0;
            held_reg   <= 1'b0;
            check_reg  <= 8'd0;
            type_reg   <= 8'd0;
            ident_reg  <= 8'd0;
            count_reg  <= '0;
            length_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            marks_reg  <= marks_next;
            held_reg   <= held_next;
            check_reg  <= check_next;
            type_reg   <= type_next;
            ident_reg  <= ident_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            ovf_reg    <= ovf_next;
        end
    end

    // result register: status fields are the live state, captured with the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            ignored_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                done_reg      <= done_c;
                ignored_reg   <= ignored_c;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    dsfr_payload_buf #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat_en  (accept),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_data  (item.rx_byte),
        .rd_en    (accept && (item.command == CMD_READ)),
        .rd_index (item.read_index),
        .rd_data  (result.read_data)
    );

    assign length_ext = {7'd0, length_reg};

    // state registers only change on accepted beats, so they match the held result
    assign result.valid            = out_valid_reg;
    assign result.frame_done       = done_reg;
    assign result.frame_held       = held_reg;
    assign result.byte_ignored     = ignored_reg;
    assign result.check_byte       = check_reg;
    assign result.type_byte        = type_reg;
    assign result.ident_byte       = ident_reg;
    assign result.payload_length   = length_ext[6:0];
    assign result.payload_overflow = ovf_reg;

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.frame_done |-> result.frame_held)
        else $error("completed frame not reported as held");

    a_ignore_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.byte_ignored |-> result.frame_held && !result.frame_done)
        else $error("byte ignored without a held frame");

    a_hold_source: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg ##1 held_reg |-> $past(done_c))
        else $error("frame held without a completing end marker");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(PAYLOAD_DEPTH))
        else $error("payload count beyond buffer depth");

    a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !held_reg && (phase_reg == PH_DATA))
        else $error("payload write outside data phase");

endmodule

/* rtl/dsfr_payload_buf.sv */
// Payload buffer: single write port, registered read port with range check.
// Depends on nothing but its parameter.
module dsfr_payload_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          beat_en,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [5:0]    rd_index,
    output logic [7:0]    rd_data
);

    logic [7:0]     mem [DEPTH];
    logic [7:0]     rd_q_reg;
    logic           rd_hit_reg;
    logic           rd_hit_next;
    logic [AW+5:0]  rd_index_ext;
    logic [AW-1:0]  rd_addr;

    assign rd_index_ext = {{AW{1'b0}}, rd_index};
    assign rd_addr      = rd_index_ext[AW-1:0];
    assign rd_hit_next  = (32'(rd_index) < 32'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && rd_hit_next)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // hit flag only moves with a new beat so a stalled result holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (beat_en)
        begin
            rd_hit_reg <= rd_en && rd_hit_next;
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg : 8'd0;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for dle_stuffed_frame_receiver: directed table, then random framed
// traffic under several marker settings, checked beat by beat against a frame predictor.
// Depends on rtl/dsfr_pkg.sv, rtl/dsfr_if.sv and the receiver RTL.
`timescale 1ns / 1ps

module testbench;
    import dsfr_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic       frame_done;
        logic       frame_held;
        logic       byte_ignored;
        logic [7:0] check_byte;
        logic [7:0] type_byte;
        logic [7:0] ident_byte;
        logic [6:0] payload_length;
        logic [7:0] read_data;
        logic       payload_overflow;
    } frame_status_t;

    typedef struct packed {
        command_t      cmd;
        logic [7:0]    rx_byte;
        logic [5:0]    read_index;
        logic          typed;
        frame_status_t want;
    } directed_row_t;

    typedef struct packed {
        logic [7:0] start_b;
        logic [7:0] end_b;
        logic [7:0] escape_b;
        logic [9:0] items;
        logic [1:0] idle_mode;
    } marker_setting_t;

    // reset markers: start 02, end 03, escape 10
    directed_row_t directed_rows [0:24] = '{
        '{CMD_NOP,     8'hFF, 6'd63, 1, '{0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_RELEASE, 8'h00, 6'd0,  1, '{0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h55, 6'd42, 1, '{0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h03, 6'd21, 1, '{0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h02, 6'd0,  1, '{0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'hFF, 6'd0,  1, '{0, 0, 0, 8'hFF, 8'h00, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h10, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h02, 6'd0,  1, '{0, 0, 0, 8'hFF, 8'h02, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h00, 6'd0,  1, '{0, 0, 0, 8'hFF, 8'h02, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h10, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h10, 6'd0,  0, '0},
        '{CMD_BYTE,    8'hFF, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h00, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h03, 6'd0,  1, '{1, 1, 0, 8'hFF, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_BYTE,    8'h02, 6'd0,  1, '{0, 1, 1, 8'hFF, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_BYTE,    8'h10, 6'd0,  1, '{0, 1, 1, 8'hFF, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_READ,    8'hAA, 6'd0,  1, '{0, 1, 0, 8'hFF, 8'h02, 8'h00, 3, 8'h10, 0}},
        '{CMD_READ,    8'h55, 6'd2,  1, '{0, 1, 0, 8'hFF, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_READ,    8'h00, 6'd1,  1, '{0, 1, 0, 8'hFF, 8'h02, 8'h00, 3, 8'hFF, 0}},
        '{CMD_RELEASE, 8'hFF, 6'd63, 1, '{0, 0, 0, 8'hFF, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_BYTE,    8'h02, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h11, 6'd0,  1, '{0, 0, 0, 8'h11, 8'h02, 8'h00, 3, 8'h00, 0}},
        '{CMD_BYTE,    8'h03, 6'd0,  1, '{0, 0, 0, 8'h11, 8'h02, 8'h00, 0, 8'h00, 0}},
        '{CMD_BYTE,    8'h10, 6'd0,  0, '0},
        '{CMD_BYTE,    8'h03, 6'd0,  0, '0}
    };

    // idle_mode: 0 sender rarely idle, 1 receiver rarely idle, 2 no idling
    marker_setting_t marker_plan [0:6] = '{
        '{8'h02, 8'h03, 8'h10, 110, 0},
        '{8'h00, 8'hFF, 8'h80, 100, 0},
        '{8'h40, 8'h40, 8'h41, 30,  0},
        '{8'hFF, 8'h00, 8'h7D, 100, 1},
        '{8'h55, 8'h56, 8'h55, 30,  1},
        '{8'h01, 8'hFE, 8'hFF, 100, 1},
        '{8'h02, 8'h03, 8'h10, 130, 2}
    };

    logic clk = 1'b0;
    logic rst_n;

    dsfr_item_if   item_ch();
    dsfr_result_if result_ch();
    dsfr_cfg_if    cfg_ch();

    dle_stuffed_frame_receiver #(.PAYLOAD_DEPTH(DEPTH)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // frame predictor state
    logic [7:0] mark_start  = START_RESET;
    logic [7:0] mark_end    = END_RESET;
    logic [7:0] mark_escape = ESCAPE_RESET;
    rx_phase_t  cur_phase = PH_IDLE;
    logic       escape_armed = 1'b0;
    logic [5:0] marks_seen = '0;
    logic       holding = 1'b0;
    logic [7:0] cap_check = '0;
    logic [7:0] cap_type = '0;
    logic [7:0] cap_ident = '0;
    logic [6:0] fill_count = '0;
    logic [6:0] last_length = '0;
    logic       dropped = 1'b0;
    logic [7:0] payload_mem [0:DEPTH-1];
    bit         payload_written [0:DEPTH-1];

    frame_status_t expected_status_q[$];
    int error_count = 0;
    int src_idle_pct = 9;
    int snk_idle_pct = 58;
    int seg_items = 0;
    int total_items = 0;
    int frames_done = 0;
    int reads_done = 0;
    int overflow_frames = 0;
    bit paused_once = 0;
    bit big_frame_due = 0;

    task automatic frame_predict(input command_t c, input logic [7:0] b, input logic [5:0] idx,
                                 output frame_status_t r);
        logic lit;
        r = '0;
        if (c == CMD_BYTE) begin
            if (holding) begin
                r.byte_ignored = 1'b1;
            end
            else if (!escape_armed && b == mark_escape) begin
                escape_armed = 1'b1;
            end
            else begin
                lit = escape_armed;
                escape_armed = 1'b0;
                if (!lit && b == mark_start) begin
                    marks_seen = MK_START;
                    fill_count = '0;
                    dropped = 1'b0;
                    cur_phase = PH_CHECK;
                end
                else if (!lit && b == mark_end) begin
                    last_length = fill_count;
                    marks_seen = marks_seen | MK_END;
                    cur_phase = PH_IDLE;
                    if ((marks_seen & MK_NEED) == MK_NEED) begin
                        marks_seen = '0;
                        holding = 1'b1;
                        r.frame_done = 1'b1;
                    end
                end
                else begin
                    case (cur_phase)
                        PH_CHECK:
                        begin
                            cap_check = b;
                            marks_seen = marks_seen | MK_CHECK;
                            cur_phase = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            cap_type = b;
                            marks_seen = marks_seen | MK_TYPE;
                            cur_phase = PH_IDENT;
                        end
                        PH_IDENT:
                        begin
                            cap_ident = b;
                            marks_seen = marks_seen | MK_IDENT;
                            cur_phase = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (fill_count < DEPTH) begin
                                payload_mem[fill_count[5:0]] = b;
                                payload_written[fill_count[5:0]] = 1'b1;
                                fill_count = fill_count + 7'd1;
                            end
                            else begin
                                dropped = 1'b1;
                            end
                            marks_seen = marks_seen | MK_DATA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (c == CMD_READ) begin
            r.read_data = payload_mem[idx];
        end
        else if (c == CMD_RELEASE) begin
            holding = 1'b0;
        end
        r.frame_held       = holding;
        r.check_byte       = cap_check;
        r.type_byte        = cap_type;
        r.ident_byte       = cap_ident;
        r.payload_length   = last_length;
        r.payload_overflow = dropped;
    endtask

    task automatic send_item(input command_t c, input logic [7:0] b, input logic [5:0] idx,
                             input logic typed, input frame_status_t want);
        frame_status_t r;
        if ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= c;
        item_ch.rx_byte    <= b;
        item_ch.read_index <= idx;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        frame_predict(c, b, idx, r);
        expected_status_q.push_back(typed ? want : r);
        total_items++;
        if (!r.byte_ignored) seg_items++;
        if (r.frame_done) frames_done++;
        if (r.frame_done && r.payload_overflow) overflow_frames++;
        if (c == CMD_READ) reads_done++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, 6'($urandom), 1'b0, '0);
    endtask

    task automatic send_cmd(input command_t c);
        send_item(c, 8'($urandom), 6'($urandom), 1'b0, '0);
    endtask

    // content byte, stuffed when it collides with a marker
    task automatic send_content(input logic [7:0] b);
        if (b == mark_escape || b == mark_start || b == mark_end) send_byte(mark_escape);
        send_byte(b);
    endtask

    function automatic logic [7:0] pick_byte(input int marker_pct);
        if ($urandom_range(99) >= marker_pct) return 8'($urandom);
        case ($urandom_range(2))
            0: return mark_start;
            1: return mark_end;
            default: return mark_escape;
        endcase
    endfunction

    // only entries already written may be read
    function automatic int pick_read_index();
        int i;
        int idx;
        if (last_length != 0 && $urandom_range(1) == 1)
            return $urandom_range(int'(last_length) - 1);
        for (i = 0; i < 8; i++) begin
            idx = $urandom_range(DEPTH - 1);
            if (payload_written[6'(idx)]) return idx;
        end
        return -1;
    endfunction

    task automatic send_read();
        int idx;
        idx = pick_read_index();
        if (idx < 0) send_cmd(CMD_NOP);
        else send_item(CMD_READ, 8'($urandom), 6'(idx), 1'b0, '0);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_status_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_markers(input marker_setting_t s);
        int i;
        logic [7:0] v;
        reg_index_t ri;
        for (i = 0; i < 4; i++) begin
            ri = reg_index_t'(i);
            case (ri)
                REG_START:  v = s.start_b;
                REG_END:    v = s.end_b;
                REG_ESCAPE: v = s.escape_b;
                default:    v = 8'($urandom);
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= ri;
            cfg_ch.data  <= v;
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            case (ri)
                REG_START:  mark_start = v;
                REG_END:    mark_end = v;
                REG_ESCAPE: mark_escape = v;
                default:    ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic serve_held_frame();
        int i;
        int n;
        n = $urandom_range(4);
        for (i = 0; i < n; i++) send_read();
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(pick_byte(40));
        end
        if ($urandom_range(4) == 0) send_cmd(CMD_NOP);
        if (!paused_once || $urandom_range(9) == 0) begin
            settle();
            paused_once = 1;
        end
        send_cmd(CMD_RELEASE);
    endtask

    task automatic send_noise();
        int i;
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 60) send_byte(pick_byte(30));
            else if (k < 75) send_read();
            else if (k < 88) send_cmd(CMD_RELEASE);
            else send_cmd(CMD_NOP);
        end
    endtask

    // flaw: 0 clean, 1 short header, 2 leading noise, 3 restart, 4 no end, 5 escaped end
    task automatic send_frame();
        int i;
        int k;
        int plen;
        int flaw;
        k = $urandom_range(99);
        if (big_frame_due) plen = $urandom_range(66, 72);
        else if (k < 75) plen = $urandom_range(6);
        else if (k < 95) plen = $urandom_range(7, 24);
        else plen = $urandom_range(58, 72);
        big_frame_due = 0;
        flaw = ($urandom_range(99) < 25) ? $urandom_range(1, 5) : 0;
        if (flaw == 2) send_noise();
        send_byte(mark_start);
        if (flaw == 1) begin
            k = $urandom_range(2);
            for (i = 0; i < k; i++) send_content(pick_byte(20));
        end
        else begin
            for (i = 0; i < 3; i++) send_content(pick_byte(20));
            if (flaw == 3) begin
                send_byte(mark_start);
                for (i = 0; i < 3; i++) send_content(pick_byte(20));
            end
            for (i = 0; i < plen; i++) send_content(pick_byte(15));
        end
        if (flaw == 5) send_byte(mark_escape);
        if (flaw != 4) send_byte(mark_end);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_status();
        frame_status_t want;
        if (expected_status_q.size() == 0) begin
            $error("result beat with no item outstanding");
            error_count++;
        end
        else begin
            want = expected_status_q.pop_front();
            check_field("frame_done", 8'(want.frame_done), 8'(result_ch.frame_done));
            check_field("frame_held", 8'(want.frame_held), 8'(result_ch.frame_held));
            check_field("byte_ignored", 8'(want.byte_ignored), 8'(result_ch.byte_ignored));
            check_field("check_byte", want.check_byte, result_ch.check_byte);
            check_field("type_byte", want.type_byte, result_ch.type_byte);
            check_field("ident_byte", want.ident_byte, result_ch.ident_byte);
            check_field("payload_length", 8'(want.payload_length),
                        8'(result_ch.payload_length));
            check_field("read_data", want.read_data, result_ch.read_data);
            check_field("payload_overflow", 8'(want.payload_overflow),
                        8'(result_ch.payload_overflow));
        end
    endtask

    initial begin : result_sink
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (result_ch.valid && result_ch.ready) check_status();
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int i;
        int s;
        foreach (payload_written[i]) payload_written[i] = 1'b0;
        foreach (payload_mem[i]) payload_mem[i] = 8'h00;
        item_ch.valid      <= 1'b0;
        item_ch.command    <= CMD_NOP;
        item_ch.rx_byte    <= 8'h00;
        item_ch.read_index <= 6'd0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_START;
        cfg_ch.data        <= 8'h00;
        rst_n              <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].rx_byte,
                      directed_rows[i].read_index, directed_rows[i].typed,
                      directed_rows[i].want);

        for (s = 0; s < 7; s++) begin
            settle();
            case (marker_plan[s].idle_mode)
                0: begin src_idle_pct = 9;  snk_idle_pct = 58; end
                1: begin src_idle_pct = 58; snk_idle_pct = 9;  end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            write_markers(marker_plan[s]);
            big_frame_due = (marker_plan[s].items >= 100);
            seg_items = 0;
            while (seg_items < marker_plan[s].items) begin
                if (holding) serve_held_frame();
                else if ($urandom_range(99) < 15) send_noise();
                else send_frame();
            end
        end

        settle();
        $display("Run covered %0d item beats over 7 marker settings: %0d frames completed",
                 total_items, frames_done);
        $display("(%0d with payload overflow) and %0d payload reads.", overflow_frames,
                 reads_done);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsfr_pkg.sv
rtl/dsfr_if.sv
rtl/dsfr_payload_buf.sv
rtl/dle_stuffed_frame_receiver.sv
tb/testbench.sv
